// File: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, quiet while reset is held
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// implication form of the above
`define ASSERT_IMPLIES(label, clk_sig, rst_n_sig, ante, cons, msg) \
	`ASSERT_CLK(label, clk_sig, rst_n_sig, (ante) |-> (cons), msg)

`endif

// File: src/dewr_pkg.sv
package dewr_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned COUNT_W   = 9;
	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned M_TDATA_W = 48;

	typedef enum logic [1:0] {
		OP_PUSH_HEAD = 2'd0,
		OP_PUSH_TAIL = 2'd1,
		OP_POP_HEAD  = 2'd2,
		OP_REVERSE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// outcome of one operation, minus the popped data
	typedef struct packed {
		status_t              status;
		logic                 pop;
		logic [COUNT_W-1:0]   count;
	} res_t;

endpackage

// File: src/dewr_ram.sv
module dewr_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [dewr_pkg::DATA_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [dewr_pkg::DATA_W-1:0] rd_data
);
	import dewr_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// read data holds until the next read
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/dewr_ctrl.sv
module dewr_ctrl #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  dewr_pkg::op_t               op,
	input  logic [dewr_pkg::DATA_W-1:0] value_in,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [dewr_pkg::DATA_W-1:0] wr_data,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	output dewr_pkg::res_t              res
);
	import dewr_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] ONE = AW'(1);

	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] fill_q, fill_d;
	logic          rev_q, rev_d;
	logic          full, empty;
	logic [AW-1:0] fill_mod, last_ofs;

	// ring position arithmetic, both operands below DEPTH
	function automatic logic [AW-1:0] padd(input logic [AW-1:0] p, input logic [AW-1:0] d);
		logic [AW:0] s;
		s = {1'b0, p} + {1'b0, d};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] psub(input logic [AW-1:0] p, input logic [AW-1:0] d);
		logic [AW:0] s;
		s = {1'b0, p} - {1'b0, d};
		if (p < d) begin
			s = s + DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	assign full     = (fill_q == CW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign fill_mod = full ? '0 : fill_q[AW-1:0];
	assign last_ofs = fill_q[AW-1:0] - ONE;

	always_comb begin
		front_d    = front_q;
		fill_d     = fill_q;
		rev_d      = rev_q;
		wr_en      = 1'b0;
		wr_addr    = front_q;
		wr_data    = value_in;
		rd_en      = 1'b0;
		rd_addr    = front_q;
		res.status = ST_OK;
		res.pop    = 1'b0;
		unique case (op)
			OP_PUSH_HEAD: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					front_d = rev_q ? padd(front_q, ONE) : psub(front_q, ONE);
					wr_en   = accept;
					wr_addr = front_d;
					fill_d  = fill_q + CW'(1);
				end
			end
			OP_PUSH_TAIL: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					wr_en   = accept;
					wr_addr = rev_q ? psub(front_q, fill_mod) : padd(front_q, fill_mod);
					fill_d  = fill_q + CW'(1);
				end
			end
			OP_POP_HEAD: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					rd_en   = accept;
					res.pop = 1'b1;
					front_d = rev_q ? psub(front_q, ONE) : padd(front_q, ONE);
					fill_d  = fill_q - CW'(1);
				end
			end
			OP_REVERSE: begin
				// head moves to the old last element, no data moves
				if (!empty) begin
					front_d = rev_q ? psub(front_q, last_ofs) : padd(front_q, last_ofs);
				end
				rev_d = !rev_q;
			end
			default: begin
			end
		endcase
		res.count = COUNT_W'(fill_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			fill_q  <= '0;
			rev_q   <= 1'b0;
		end else if (accept) begin
			front_q <= front_d;
			fill_q  <= fill_d;
			rev_q   <= rev_d;
		end
	end

endmodule

// File: src/double_ended_queue_with_reverse.sv
// Bounded deque of signed 32-bit values in a DEPTH-entry ring held in one
// synchronous RAM. Each beat on s is one operation (push head, push tail,
// pop head, reverse) and gives exactly one beat on m with status, popped
// value and the element count after the operation. One operation is taken
// per clock cycle while m keeps up. The RAM read is made at the edge that
// takes the operation; stage 1 then holds the result until the output
// register is free, and m_tvalid rises once it is loaded.
// Reverse only flips a direction bit and moves the head pointer. No clearing
// pass is needed after reset.
`include "assert_macros.svh"

module double_ended_queue_with_reverse #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dewr_pkg::S_TDATA_W-1:0] s_tdata,  // op[1:0], value_in[33:2]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dewr_pkg::M_TDATA_W-1:0] m_tdata   // status[1:0], value_out[33:2], count[42:34]
);
	import dewr_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              accept, adv;
	op_t               op;
	logic [DATA_W-1:0] value_in;
	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [DATA_W-1:0] wr_data, rd_data;
	res_t              res;

	logic              valid_s1;
	res_t              res_s1;
	logic              out_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] value_q;
	logic [COUNT_W-1:0] count_q;

	assign op       = op_t'(s_tdata[1:0]);
	assign value_in = s_tdata[DATA_W+1:2];

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	dewr_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.op       (op),
		.value_in (value_in),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.res      (res)
	);

	dewr_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// stage 1 waits for the ram read, ram data holds while it stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= res_s1.status;
			value_q  <= res_s1.pop ? rd_data : '0;
			count_q  <= res_s1.count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - 2 - DATA_W - COUNT_W){1'b0}}, count_q, value_q, status_q};

	`ASSERT_IMPLIES(a_empty_zero_count, clk, arst_n,
		out_valid_q && status_q == ST_EMPTY, count_q == '0, "empty status with nonzero count")
	`ASSERT_IMPLIES(a_full_count, clk, arst_n,
		out_valid_q && status_q == ST_FULL, count_q == COUNT_W'(DEPTH), "full status below capacity")
	`ASSERT_IMPLIES(a_value_only_on_ok, clk, arst_n,
		out_valid_q && status_q != ST_OK, value_q == '0, "value returned on failed operation")
	`ASSERT_CLK(a_s1_holds, clk, arst_n,
		(valid_s1 && !adv) |=> (valid_s1 && $stable(res_s1)), "stalled stage 1 lost its result")

endmodule

// File: tb/sv/double_ended_queue_with_reverse_tb.sv
`timescale 1ns / 100ps

module double_ended_queue_with_reverse_tb;
	import dewr_pkg::*;

	localparam int unsigned RING_DEPTH = 256;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned PHASE_OPS  = 440;

	typedef struct packed {
		status_t                    status;
		logic signed [DATA_W-1:0]   value;
		logic        [COUNT_W-1:0]  count;
	} deque_result_t;

	// mirror of the ring: head position, fill level and direction bit
	class deque_scoreboard;
		logic [DATA_W-1:0] ring [RING_DEPTH];
		logic [7:0]        head_pos;
		logic [8:0]        fill;
		bit                backward;
		deque_result_t     expected_q[$];
		int                errors;

		function new();
			head_pos = '0;
			fill     = '0;
			backward = 1'b0;
			errors   = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_op(op_t op, logic [DATA_W-1:0] v);
			deque_result_t r;
			logic [7:0]    slot;
			r.status = ST_OK;
			r.value  = '0;
			case (op)
				OP_PUSH_HEAD: begin
					if (fill == RING_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						head_pos = backward ? head_pos + 8'd1 : head_pos - 8'd1;
						ring[head_pos] = v;
						fill++;
					end
				end
				OP_PUSH_TAIL: begin
					if (fill == RING_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						slot = backward ? head_pos - fill[7:0] : head_pos + fill[7:0];
						ring[slot] = v;
						fill++;
					end
				end
				OP_POP_HEAD: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.value  = ring[head_pos];
						head_pos = backward ? head_pos - 8'd1 : head_pos + 8'd1;
						fill--;
					end
				end
				default: begin
					// new head is the old last element
					if (fill != 0) begin
						slot     = 8'(fill - 9'd1);
						head_pos = backward ? head_pos - slot : head_pos + slot;
					end
					backward = !backward;
				end
			endcase
			r.count = fill;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] beat);
			deque_result_t want;
			logic [1:0]               got_status;
			logic signed [DATA_W-1:0] got_value;
			logic [COUNT_W-1:0]       got_count;
			got_status = beat[1:0];
			got_value  = beat[33:2];
			got_count  = beat[42:34];
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with no operation pending, status %0d value %0d count %0d",
					$time, got_status, got_value, got_count);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got_status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
				errors++;
			end
			if (got_value !== want.value) begin
				$display("%0t: value expected %0d actual %0d", $time, want.value, got_value);
				errors++;
			end
			if (got_count !== want.count) begin
				$display("%0t: count expected %0d actual %0d", $time, want.count, got_count);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;

	deque_scoreboard sb = new();
	int              burst_left = 0;
	int              idle_cycles = 0;

	double_ended_queue_with_reverse #(
		.DEPTH(RING_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// accepted beats on both sides, plus the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_op(op_t'(s_tdata[1:0]), s_tdata[33:2]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("double_ended_queue_with_reverse_tb NOT OK");
					$finish;
				end
			end
		end
	end

	// receiver stalls: always ready, coin flip, one in three, or mostly stalled
	initial begin
		int mode;
		int tick;
		m_tready <= 1'b0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				tick++;
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= (tick % 3 == 0);
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	task automatic issue(input op_t op, input logic [DATA_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - 34){1'b0}}, v, op};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_for_results();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op(int push_w, int pop_w, int rev_w);
		int roll;
		roll = $urandom_range(0, push_w + pop_w + rev_w - 1);
		if (roll < push_w)
			return $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
		if (roll < push_w + pop_w)
			return OP_POP_HEAD;
		return OP_REVERSE;
	endfunction

	task automatic run_phase(int n, int push_w, int pop_w, int rev_w);
		op_t op;
		repeat (n) begin
			op = pick_op(push_w, pop_w, rev_w);
			issue(op, (op == OP_POP_HEAD || op == OP_REVERSE) ? $urandom : pick_value());
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty cases, extremes, reversal with content
		issue(OP_POP_HEAD,  32'h0000_0000);
		issue(OP_REVERSE,   32'h0000_0000);
		issue(OP_POP_HEAD,  32'hffff_ffff);
		issue(OP_REVERSE,   32'hffff_ffff);
		issue(OP_PUSH_HEAD, 32'h7fff_ffff);
		issue(OP_PUSH_TAIL, 32'h8000_0000);
		issue(OP_PUSH_HEAD, 32'hffff_ffff);
		issue(OP_PUSH_TAIL, 32'h0000_0000);
		issue(OP_POP_HEAD,  32'h0000_0000);
		issue(OP_REVERSE,   32'h0000_0000);
		issue(OP_POP_HEAD,  32'h0000_0000);
		issue(OP_PUSH_HEAD, 32'h5555_5555);
		issue(OP_PUSH_TAIL, 32'haaaa_aaaa);
		issue(OP_REVERSE,   32'h0000_0000);
		issue(OP_POP_HEAD,  32'h0000_0000);
		issue(OP_POP_HEAD,  32'h0000_0000);
		issue(OP_POP_HEAD,  32'h0000_0000);
		issue(OP_POP_HEAD,  32'h0000_0000);
		issue(OP_POP_HEAD,  32'h0000_0000);
		issue(OP_PUSH_TAIL, 32'h0000_0001);
		issue(OP_REVERSE,   32'h0000_0000);
		issue(OP_PUSH_HEAD, 32'h8000_0001);
		issue(OP_POP_HEAD,  32'h0000_0000);
		issue(OP_POP_HEAD,  32'h0000_0000);
		wait_for_results();

		// fill to the top and sit there, drain past empty, then a mixed phase and a second fill
		run_phase(PHASE_OPS, 80, 10, 10);
		wait_for_results();
		run_phase(PHASE_OPS, 15, 75, 10);
		run_phase(PHASE_OPS, 34, 33, 33);
		wait_for_results();
		run_phase(PHASE_OPS, 85, 5, 10);

		wait_for_results();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("double_ended_queue_with_reverse_tb OK");
		else
			$display("double_ended_queue_with_reverse_tb NOT OK");
		$finish;
	end

endmodule
